/* rtl/swrl_pkg.sv */
// ----------------------------------------------------------------------------
// swrl_pkg
// Shared constants, types and table helpers for the sRGB white-level rescale.
// ----------------------------------------------------------------------------
`default_nettype none

package swrl_pkg;

  localparam int LINEAR_FRAC_BITS_DEF  = 16;
  localparam int ENCODE_INDEX_BITS_DEF = 12;

  localparam int CALC_BITS  = 30;
  localparam int CODE_BITS  = 8;
  localparam int CODE_COUNT = 1 << CODE_BITS;

  localparam int CFG_BITS   = 18;
  localparam int CFG_BYTES  = (CFG_BITS + 7) / 8;
  localparam int GAIN_BITS  = 17;
  localparam int GAIN_FRAC  = 16;
  localparam int UNITY_GAIN = 1 << GAIN_FRAC;
  localparam int WHITE_REF  = 1280;
  localparam int REF_NUM    = WHITE_REF * UNITY_GAIN;
  localparam int DIV_BITS   = $clog2(REF_NUM + (1 << (CFG_BITS - 1)));
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

  localparam int PIX_BITS   = 3 * CODE_BITS;

  typedef struct packed {
    logic adv_mul;
    logic adv_enc;
  } lane_ctrl_t;

  typedef struct packed {
    logic                 busy;
    logic [GAIN_BITS-1:0] gain;
  } gain_stat_t;

  // unsigned quotient by shift and subtract
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    int          b;
    rem = '0;
    quo = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sRGB decode of n/d to linear light, Q0.30
  function automatic logic [63:0] decode_q30(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] half;
    logic [63:0] sn;
    logic [63:0] sd;
    logic [63:0] s;
    logic [63:0] s2;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] y4;
    logic [63:0] q;
    logic [63:0] r;
    int          i;
    half = 64'd1 << (CALC_BITS - 1);
    r    = 64'd0;
    if (n * 64'd100000 <= 64'd4045 * d) begin
      r = udiv64(((n * 64'd100) << CALC_BITS) + 64'd646 * d, 64'd1292 * d);
    end else begin
      sn = 64'd1000 * n + 64'd55 * d;
      sd = 64'd1055 * d;
      s  = udiv64((sn << CALC_BITS) + (sd >> 1), sd);
      s2 = (s * s + half) >> CALC_BITS;
      y  = 64'd1 << CALC_BITS;
      for (i = 0; i < 40; i++) begin
        y2 = (y * y + half) >> CALC_BITS;
        y4 = (y2 * y2 + half) >> CALC_BITS;
        if (y4 == 64'd0) begin
          y4 = 64'd1;
        end
        q = udiv64(s2 << CALC_BITS, y4);
        y = udiv64(64'd4 * y + q, 64'd5);
      end
      r = (s2 * y + half) >> CALC_BITS;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/srgb_white_level_rescale.sv */
// ----------------------------------------------------------------------------
// srgb_white_level_rescale
// Rescales sRGB pixels by min(1, 80 nits / SDR white level) in linear light.
//
// in_*  : one pixel per transaction; tdata holds blue, green, red bytes,
//         tlast marks the last pixel of a frame.
// out_* : one rescaled pixel per input transaction, same packing and tlast.
// cfg_* : writes the SDR white level (nits times 16). Unity gain at or below
//         80 nits; otherwise the gain comes from a bit-serial divider,
//         during which cfg_tready and in_tready are low.
// Three channel lanes run side by side; each has a multiply stage and an
// encode-table stage, with throughput one pixel per cycle while the output
// is not stalled and the divider is not busy. A stalled output holds its
// pixel; an empty pipeline stage still accepts input while the output waits.
// Reset restores unity gain and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module srgb_white_level_rescale #(
  parameter int LINEAR_FRAC_BITS  = swrl_pkg::LINEAR_FRAC_BITS_DEF,
  parameter int ENCODE_INDEX_BITS = swrl_pkg::ENCODE_INDEX_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // tdata: blue_in, green_in, red_in
  input  wire logic [swrl_pkg::PIX_BITS-1:0]         in_tdata,
  input  wire logic                                  in_tlast,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // tdata: blue_out, green_out, red_out
  output logic [swrl_pkg::PIX_BITS-1:0]              out_tdata,
  output logic                                       out_tlast,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // tdata: white_level_sixteenths
  input  wire logic [swrl_pkg::CFG_BYTES*8-1:0]      cfg_tdata,
  input  wire logic                                  cfg_tvalid,
  output logic                                       cfg_tready
);
  import swrl_pkg::*;

  gain_stat_t gstat;
  lane_ctrl_t ctrl;
  logic       cfg_acc;
  logic       in_acc;
  logic       s1_v_r;
  logic       s1_last_r;
  logic       out_v_r;
  logic       out_last_r;

  assign cfg_tready = !gstat.busy;
  assign cfg_acc    = cfg_tvalid && cfg_tready;

  swrl_gain_div u_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_acc),
    .wr_level (cfg_tdata[CFG_BITS-1:0]),
    .stat     (gstat)
  );

  assign ctrl.adv_enc = !out_v_r || out_tready;
  assign ctrl.adv_mul = !s1_v_r || ctrl.adv_enc;
  assign in_tready    = ctrl.adv_mul && !gstat.busy;
  assign in_acc       = in_tvalid && in_tready;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    swrl_lane #(
      .LINEAR_FRAC_BITS  (LINEAR_FRAC_BITS),
      .ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
    ) u_lane (
      .clk   (clk),
      .code  (in_tdata[g*CODE_BITS +: CODE_BITS]),
      .gain  (gstat.gain),
      .ctrl  (ctrl),
      .enc_o (out_tdata[g*CODE_BITS +: CODE_BITS])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ctrl.adv_mul) begin
        s1_v_r <= in_acc;
      end
      if (ctrl.adv_enc) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv_mul) begin
      s1_last_r <= in_tlast;
    end
    if (ctrl.adv_enc) begin
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* rtl/swrl_gain_div.sv */
// ----------------------------------------------------------------------------
// swrl_gain_div
// Holds the linear gain: unity up to white reference, else restoring division.
// ----------------------------------------------------------------------------
`default_nettype none

module swrl_gain_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_en,
  input  wire logic [swrl_pkg::CFG_BITS-1:0]    wr_level,
  output swrl_pkg::gain_stat_t                  stat
);
  import swrl_pkg::*;

  logic [GAIN_BITS-1:0]    gain_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic [DIV_BITS-1:0]     num_r;
  logic [CFG_BITS-1:0]     rem_r;
  logic [CFG_BITS-1:0]     den_r;

  logic [CFG_BITS:0]       trial;
  logic                    ge;
  logic [CFG_BITS-1:0]     rem_nxt;
  logic [DIV_BITS-1:0]     num_nxt;

  assign trial   = {rem_r, num_r[DIV_BITS-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? CFG_BITS'(trial - {1'b0, den_r}) : trial[CFG_BITS-1:0];
  assign num_nxt = {num_r[DIV_BITS-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_BITS'(UNITY_GAIN);
      cnt_r  <= '0;
    end else if (wr_en) begin
      if (wr_level <= CFG_BITS'(WHITE_REF)) begin
        gain_r <= GAIN_BITS'(UNITY_GAIN);
      end else begin
        cnt_r <= DIV_CNT_BITS'(DIV_BITS);
      end
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_BITS'(1)) begin
        gain_r <= num_nxt[GAIN_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      num_r <= DIV_BITS'(REF_NUM) + DIV_BITS'(wr_level >> 1);
      rem_r <= '0;
      den_r <= wr_level;
    end else if (cnt_r != '0) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = cnt_r != '0;
  assign stat.gain = gain_r;

endmodule

`default_nettype wire

/* rtl/swrl_lane.sv */
// ----------------------------------------------------------------------------
// swrl_lane
// One color channel: decode table, gain multiply, clamp, encode table.
// ----------------------------------------------------------------------------
`default_nettype none

module swrl_lane #(
  parameter int LINEAR_FRAC_BITS  = swrl_pkg::LINEAR_FRAC_BITS_DEF,
  parameter int ENCODE_INDEX_BITS = swrl_pkg::ENCODE_INDEX_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic [swrl_pkg::CODE_BITS-1:0]    code,
  input  wire logic [swrl_pkg::GAIN_BITS-1:0]    gain,
  input  swrl_pkg::lane_ctrl_t                   ctrl,
  output logic [swrl_pkg::CODE_BITS-1:0]         enc_o
);
  import swrl_pkg::*;

  localparam int LW       = LINEAR_FRAC_BITS + 1;
  localparam int PW       = LW + GAIN_BITS;
  localparam int ENC_SIZE = (1 << ENCODE_INDEX_BITS) + 1;
  localparam int IW       = ENCODE_INDEX_BITS + 1;
  localparam int SH_DN    = (LINEAR_FRAC_BITS > ENCODE_INDEX_BITS) ?
                            LINEAR_FRAC_BITS - ENCODE_INDEX_BITS : 0;
  localparam int SH_UP    = (ENCODE_INDEX_BITS > LINEAR_FRAC_BITS) ?
                            ENCODE_INDEX_BITS - LINEAR_FRAC_BITS : 0;
  localparam int WT       = LINEAR_FRAC_BITS + ENCODE_INDEX_BITS + 2;
  localparam logic [WT-1:0] RND = (SH_DN > 0) ? (WT'(1) << (SH_DN - 1)) : '0;
  localparam logic [LW-1:0] ONE = LW'(1) << LINEAR_FRAC_BITS;
  localparam logic [IW-1:0] IDX_MAX = IW'(1) << ENCODE_INDEX_BITS;

  function automatic logic [CODE_COUNT*LW-1:0] build_dec();
    logic [CODE_COUNT*LW-1:0] tab;
    logic [63:0]              v;
    int                       c;
    tab = '0;
    for (c = 0; c < CODE_COUNT; c++) begin
      v = decode_q30(64'(c), 64'd255);
      v = (v + (64'd1 << (CALC_BITS - LINEAR_FRAC_BITS - 1))) >> (CALC_BITS - LINEAR_FRAC_BITS);
      tab[c*LW +: LW] = v[LW-1:0];
    end
    return tab;
  endfunction

  function automatic logic [ENC_SIZE*CODE_BITS-1:0] build_enc();
    logic [ENC_SIZE*CODE_BITS-1:0] tab;
    logic [63:0]                   thr [CODE_COUNT-1];
    logic [63:0]                   pos;
    int                            j;
    int                            k;
    tab = '0;
    for (k = 0; k < CODE_COUNT - 1; k++) begin
      thr[k] = decode_q30(64'(2 * k + 1), 64'd510);
    end
    k = 0;
    for (j = 0; j < ENC_SIZE; j++) begin
      pos = 64'(j) << (CALC_BITS - ENCODE_INDEX_BITS);
      while (k < CODE_COUNT - 1 && thr[k] <= pos) begin
        k++;
      end
      tab[j*CODE_BITS +: CODE_BITS] = CODE_BITS'(k);
    end
    return tab;
  endfunction

  localparam logic [CODE_COUNT*LW-1:0]       DEC_ROM = build_dec();
  localparam logic [ENC_SIZE*CODE_BITS-1:0]  ENC_ROM = build_enc();

  logic [LW-1:0]        lin;
  logic [PW-1:0]        prod_r;
  logic [PW:0]          rsum;
  logic [LW-1:0]        x;
  logic [WT-1:0]        t;
  logic [IW-1:0]        idx;
  logic [CODE_BITS-1:0] enc_r;

  assign lin = DEC_ROM[code*LW +: LW];

  always_ff @(posedge clk) begin
    if (ctrl.adv_mul) begin
      prod_r <= PW'(lin * gain);
    end
  end

  always_comb begin
    rsum = ({1'b0, prod_r} + (PW+1)'(1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
    if (rsum > (PW+1)'(ONE)) begin
      x = ONE;
    end else begin
      x = rsum[LW-1:0];
    end
    t = ((WT'(x) + RND) >> SH_DN) << SH_UP;
    if (t > WT'(IDX_MAX)) begin
      idx = IDX_MAX;
    end else begin
      idx = t[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv_enc) begin
      enc_r <= ENC_ROM[idx*CODE_BITS +: CODE_BITS];
    end
  end

  assign enc_o = enc_r;

endmodule

`default_nettype wire
